>>> rtl/core/gsgc_pkg.sv
// Shared types, constants and helpers for the gap-skipping scaled guest clock.
package gsgc_pkg;

  localparam int unsigned SpeedWidth = 8;
  localparam int unsigned GapWidth   = 40;
  localparam int unsigned TimeWidth  = 64;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned CfgWidth   = GapWidth;

  localparam logic [GapWidth-1:0] GapReset = GapWidth'(64'd250000000);

  localparam logic [1:0] ACT_ADVANCE   = 2'd0;
  localparam logic [1:0] ACT_PEEK      = 2'd1;
  localparam logic [1:0] ACT_SET_SPEED = 2'd2;

  localparam logic CFG_INITIAL_SPEED = 1'b0;
  localparam logic CFG_GAP_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [1:0]            action;
    logic [TimeWidth-1:0]  host_ns;
    logic                  pause_request;
    logic [SpeedWidth-1:0] new_speed;
  } item_t;

  typedef struct packed {
    logic                  started;
    logic [TimeWidth-1:0]  last_host;
    logic [TimeWidth-1:0]  guest;
    logic [SpeedWidth-1:0] speed;
    logic [CountWidth-1:0] epoch;
    logic [CountWidth-1:0] gaps;
    logic [TimeWidth-1:0]  excluded;
    logic                  paused;
  } state_t;

  typedef struct packed {
    logic [TimeWidth-1:0]  guest_ns;
    logic [CountWidth-1:0] epoch;
    logic [CountWidth-1:0] gap_count;
    logic [TimeWidth-1:0]  excluded_ns;
    logic                  gap_seen;
    logic [TimeWidth-1:0]  gap_length_ns;
    logic                  is_paused;
    logic [SpeedWidth-1:0] speed_now;
  } result_t;

  // A multiplier of zero runs at unit speed.
  function automatic logic [SpeedWidth-1:0] norm_speed(input logic [SpeedWidth-1:0] s);
    return (s == '0) ? {{(SpeedWidth-1){1'b0}}, 1'b1} : s;
  endfunction

endpackage

>>> rtl/core/gsgc_step.sv
// Next-state and result logic for one transaction of the guest clock.
module gsgc_step (
  input  gsgc_pkg::item_t                     item_i,
  input  gsgc_pkg::state_t                    state_i,
  input  logic [gsgc_pkg::GapWidth-1:0]       gap_thr_i,
  output gsgc_pkg::state_t                    state_o,
  output logic                                write_o,
  output gsgc_pkg::result_t                   result_o
);

  logic [gsgc_pkg::TimeWidth-1:0] diff;
  logic [gsgc_pkg::TimeWidth-1:0] scaled;
  logic                           fwd;
  logic                           gap_hit;
  logic                           is_adv;
  logic                           gap;
  logic [gsgc_pkg::TimeWidth-1:0] gap_len;
  logic [gsgc_pkg::TimeWidth-1:0] peek_guest;
  gsgc_pkg::state_t               nx;

  assign diff    = item_i.host_ns - state_i.last_host;
  assign fwd     = item_i.host_ns > state_i.last_host;
  assign scaled  = diff * gsgc_pkg::TimeWidth'(state_i.speed);
  assign gap_hit = (gap_thr_i != '0) && (diff > gsgc_pkg::TimeWidth'(gap_thr_i));
  assign is_adv  = (item_i.action == gsgc_pkg::ACT_ADVANCE) ||
                   (item_i.action == gsgc_pkg::ACT_SET_SPEED);

  always_comb begin
    nx      = state_i;
    gap     = 1'b0;
    gap_len = '0;
    if (!state_i.started) begin
      nx.started   = 1'b1;
      nx.last_host = item_i.host_ns;
    end else if (item_i.pause_request != state_i.paused) begin
      // pause/resume edge: latch host time even if it went backward
      if (item_i.pause_request) begin
        if (fwd) nx.guest = state_i.guest + scaled;
        nx.paused = 1'b1;
      end else begin
        if (fwd) nx.excluded = state_i.excluded + diff;
        nx.paused = 1'b0;
        nx.epoch  = state_i.epoch + 1'b1;
      end
      nx.last_host = item_i.host_ns;
    end else if (!state_i.paused && fwd) begin
      nx.last_host = item_i.host_ns;
      if (gap_hit) begin
        nx.gaps     = state_i.gaps + 1'b1;
        nx.excluded = state_i.excluded + diff;
        nx.epoch    = state_i.epoch + 1'b1;
        gap         = 1'b1;
        gap_len     = diff;
      end else begin
        nx.guest = state_i.guest + scaled;
      end
    end
    if (item_i.action == gsgc_pkg::ACT_SET_SPEED) begin
      nx.speed = gsgc_pkg::norm_speed(item_i.new_speed);
      nx.epoch = nx.epoch + 1'b1;
    end
  end

  assign peek_guest = (state_i.started && !state_i.paused && fwd && !gap_hit) ?
                      (state_i.guest + scaled) : state_i.guest;

  assign state_o = is_adv ? nx : state_i;
  assign write_o = is_adv;

  always_comb begin
    result_o.guest_ns      = is_adv ? nx.guest : peek_guest;
    result_o.epoch         = state_o.epoch;
    result_o.gap_count     = state_o.gaps;
    result_o.excluded_ns   = state_o.excluded;
    result_o.gap_seen      = is_adv & gap;
    result_o.gap_length_ns = is_adv ? gap_len : '0;
    result_o.is_paused     = state_o.paused;
    result_o.speed_now     = state_o.speed;
  end

endmodule

>>> rtl/core/gap_skipping_scaled_guest_clock.sv
// Gap-skipping scaled guest clock: one transaction per cycle while the output is not stalled;
// a transaction passes the input register, then one pass through the step logic into the
// result register. The clock state is updated in that same pass, so the state loop (host
// delta subtract, 64x8 multiply by the current speed, 64-bit add) sets the clock
// frequency. An input transaction is taken while a finished result waits; the block
// stalls input only when both the input and result registers are full. Config writes
// take effect on the next cycle; a write to initial_speed also loads the current speed.
module gap_skipping_scaled_guest_clock (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [gsgc_pkg::CfgWidth-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic [gsgc_pkg::TimeWidth-1:0]      host_ns_i,
  input  logic                                pause_request_i,
  input  logic [gsgc_pkg::SpeedWidth-1:0]     new_speed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gsgc_pkg::TimeWidth-1:0]      guest_ns_o,
  output logic [gsgc_pkg::CountWidth-1:0]     epoch_o,
  output logic [gsgc_pkg::CountWidth-1:0]     gap_count_o,
  output logic [gsgc_pkg::TimeWidth-1:0]      excluded_ns_o,
  output logic                                gap_seen_o,
  output logic [gsgc_pkg::TimeWidth-1:0]      gap_length_ns_o,
  output logic                                is_paused_o,
  output logic [gsgc_pkg::SpeedWidth-1:0]     speed_now_o
);

  gsgc_pkg::item_t               item_q;
  logic                          in_v_q;
  gsgc_pkg::state_t              state_q, state_d;
  logic [gsgc_pkg::GapWidth-1:0] gap_thr_q;
  gsgc_pkg::result_t             res_q, res_d;
  logic                          out_v_q;
  logic                          fire;
  logic                          accept;
  logic                          wr_state;

  assign fire       = in_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = in_v_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  gsgc_step u_step (
    .item_i    (item_q),
    .state_i   (state_q),
    .gap_thr_i (gap_thr_q),
    .state_o   (state_d),
    .write_o   (wr_state),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q <= accept || (in_v_q && !fire);
      if (fire) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action        <= action_i;
      item_q.host_ns       <= host_ns_i;
      item_q.pause_request <= pause_request_i;
      item_q.new_speed     <= new_speed_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.started   <= 1'b0;
      state_q.last_host <= '0;
      state_q.guest     <= '0;
      state_q.speed     <= gsgc_pkg::norm_speed('0);
      state_q.epoch     <= '0;
      state_q.gaps      <= '0;
      state_q.excluded  <= '0;
      state_q.paused    <= 1'b0;
      gap_thr_q         <= gsgc_pkg::GapReset;
    end else begin
      if (fire && wr_state) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gsgc_pkg::CFG_INITIAL_SPEED: begin
            state_q.speed <= gsgc_pkg::norm_speed(cfg_data_i[gsgc_pkg::SpeedWidth-1:0]);
          end
          gsgc_pkg::CFG_GAP_THRESHOLD: begin
            gap_thr_q <= cfg_data_i[gsgc_pkg::GapWidth-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign guest_ns_o      = res_q.guest_ns;
  assign epoch_o         = res_q.epoch;
  assign gap_count_o     = res_q.gap_count;
  assign excluded_ns_o   = res_q.excluded_ns;
  assign gap_seen_o      = res_q.gap_seen;
  assign gap_length_ns_o = res_q.gap_length_ns;
  assign is_paused_o     = res_q.is_paused;
  assign speed_now_o     = res_q.speed_now;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the gap-skipping scaled guest clock.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsgc_pkg::*;

  // The two-bit action code left over by the package decodes as a peek.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  class guest_clock_predictor;
    bit                    started;
    logic [TimeWidth-1:0]  last_host;
    logic [TimeWidth-1:0]  guest;
    logic [TimeWidth-1:0]  excluded;
    logic [SpeedWidth-1:0] speed;
    logic [CountWidth-1:0] epoch;
    logic [CountWidth-1:0] gaps;
    bit                    paused;
    logic [GapWidth-1:0]   gap_thr;
    result_t               expected_q[$];
    int unsigned           failures;

    function new();
      started   = 1'b0;
      last_host = '0;
      guest     = '0;
      excluded  = '0;
      speed     = 8'd1;
      epoch     = '0;
      gaps      = '0;
      paused    = 1'b0;
      gap_thr   = GapReset;
      failures  = 0;
    endfunction

    function void write_reg(logic idx, logic [CfgWidth-1:0] data);
      if (idx == CFG_INITIAL_SPEED) begin
        speed = (data[SpeedWidth-1:0] == '0) ? 8'd1 : data[SpeedWidth-1:0];
      end else begin
        gap_thr = data[GapWidth-1:0];
      end
    endfunction

    function void note_item(item_t it);
      result_t              r;
      logic [TimeWidth-1:0] d;
      logic [TimeWidth-1:0] g;
      logic [TimeWidth-1:0] glen;
      bit                   gap;
      gap  = 1'b0;
      glen = '0;
      if (it.action == ACT_ADVANCE || it.action == ACT_SET_SPEED) begin
        if (!started) begin
          started   = 1'b1;
          last_host = it.host_ns;
        end else if (it.pause_request != paused) begin
          if (it.pause_request) begin
            if (it.host_ns > last_host) guest += (it.host_ns - last_host) * speed;
            paused = 1'b1;
          end else begin
            if (it.host_ns > last_host) excluded += it.host_ns - last_host;
            paused = 1'b0;
            epoch++;
          end
          last_host = it.host_ns;
        end else if (!paused && it.host_ns > last_host) begin
          d         = it.host_ns - last_host;
          last_host = it.host_ns;
          if (gap_thr != '0 && d > {24'd0, gap_thr}) begin
            gaps++;
            excluded += d;
            epoch++;
            gap  = 1'b1;
            glen = d;
          end else begin
            guest += d * speed;
          end
        end
        if (it.action == ACT_SET_SPEED) begin
          speed = (it.new_speed == '0) ? 8'd1 : it.new_speed;
          epoch++;
        end
        g = guest;
      end else begin
        // peek: project only
        g = guest;
        if (started && !paused && it.host_ns > last_host) begin
          d = it.host_ns - last_host;
          if (!(gap_thr != '0 && d > {24'd0, gap_thr})) g = guest + d * speed;
        end
      end
      r.guest_ns      = g;
      r.epoch         = epoch;
      r.gap_count     = gaps;
      r.excluded_ns   = excluded;
      r.gap_seen      = gap;
      r.gap_length_ns = glen;
      r.is_paused     = paused;
      r.speed_now     = speed;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with no expected result pending");
        failures++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("guest_ns", e.guest_ns, got.guest_ns);
      compare_field("epoch", 64'(e.epoch), 64'(got.epoch));
      compare_field("gap_count", 64'(e.gap_count), 64'(got.gap_count));
      compare_field("excluded_ns", e.excluded_ns, got.excluded_ns);
      compare_field("gap_seen", 64'(e.gap_seen), 64'(got.gap_seen));
      compare_field("gap_length_ns", e.gap_length_ns, got.gap_length_ns);
      compare_field("is_paused", 64'(e.is_paused), 64'(got.is_paused));
      compare_field("speed_now", 64'(e.speed_now), 64'(got.speed_now));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CfgWidth-1:0]   cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            action_i;
  logic [TimeWidth-1:0]  host_ns_i;
  logic                  pause_request_i;
  logic [SpeedWidth-1:0] new_speed_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [TimeWidth-1:0]  guest_ns_o;
  logic [CountWidth-1:0] epoch_o;
  logic [CountWidth-1:0] gap_count_o;
  logic [TimeWidth-1:0]  excluded_ns_o;
  logic                  gap_seen_o;
  logic [TimeWidth-1:0]  gap_length_ns_o;
  logic                  is_paused_o;
  logic [SpeedWidth-1:0] speed_now_o;

  gap_skipping_scaled_guest_clock dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .host_ns_i       (host_ns_i),
    .pause_request_i (pause_request_i),
    .new_speed_i     (new_speed_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .guest_ns_o      (guest_ns_o),
    .epoch_o         (epoch_o),
    .gap_count_o     (gap_count_o),
    .excluded_ns_o   (excluded_ns_o),
    .gap_seen_o      (gap_seen_o),
    .gap_length_ns_o (gap_length_ns_o),
    .is_paused_o     (is_paused_o),
    .speed_now_o     (speed_now_o)
  );

  guest_clock_predictor clock_model = new();

  int unsigned          send_idle_pct;
  int unsigned          stall_pct;
  bit                   hold_off_req;
  int unsigned          hold_off_len;
  logic [TimeWidth-1:0] host_cursor;
  bit                   pause_level;
  logic [GapWidth-1:0]  thr_now;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("** gap_skipping_scaled_guest_clock: FAILED **");
    $finish;
  end

  // Receiver: random stall, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left    = hold_off_len;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.guest_ns      = guest_ns_o;
      got.epoch         = epoch_o;
      got.gap_count     = gap_count_o;
      got.excluded_ns   = excluded_ns_o;
      got.gap_seen      = gap_seen_o;
      got.gap_length_ns = gap_length_ns_o;
      got.is_paused     = is_paused_o;
      got.speed_now     = speed_now_o;
      clock_model.check_result(got);
    end
  end

  // Offers one transaction and returns with valid still high after it is taken.
  task automatic send_item(item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    action_i        = it.action;
    host_ns_i       = it.host_ns;
    pause_request_i = it.pause_request;
    new_speed_i     = it.new_speed;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    clock_model.note_item(it);
  endtask

  task automatic send_fields(logic [1:0] act, logic [63:0] host, logic req, logic [7:0] spd);
    item_t it;
    it.action        = act;
    it.host_ns       = host;
    it.pause_request = req;
    it.new_speed     = spd;
    send_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (clock_model.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgWidth-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    clock_model.write_reg(idx, data);
    if (idx == CFG_GAP_THRESHOLD) thr_now = data;
  endtask

  task automatic random_item(output item_t it);
    int unsigned          r;
    logic [TimeWidth-1:0] host;
    r = $urandom_range(99);
    if (r < 55) begin
      host_cursor += $urandom_range(2000, 1);
      host = host_cursor;
    end else if (r < 68) begin
      host_cursor += $urandom;
      host = host_cursor;
    end else if (r < 76) begin
      host_cursor += {24'd0, thr_now} + $urandom_range(1000, 1);
      host = host_cursor;
    end else if (r < 80) begin
      host_cursor += {24'd0, thr_now};
      host = host_cursor;
    end else if (r < 87) begin
      host = host_cursor - $urandom_range(3000);
    end else if (r < 93) begin
      host_cursor = {$urandom, $urandom};
      host = host_cursor;
    end else begin
      host = host_cursor;
    end
    if ($urandom_range(99) < 6) pause_level = ~pause_level;
    r = $urandom_range(99);
    if (r < 60)      it.action = ACT_ADVANCE;
    else if (r < 83) it.action = ACT_PEEK;
    else if (r < 95) it.action = ACT_SET_SPEED;
    else             it.action = ACT_SPARE;
    it.host_ns = host;
    // mostly a well-formed pause level, a little noise on it
    it.pause_request = ($urandom_range(99) < 3) ? ~pause_level : pause_level;
    it.new_speed     = 8'($urandom_range(255));
  endtask

  initial begin
    logic [63:0]         h;
    item_t               it;
    logic [7:0]          speeds[6];
    logic [GapWidth-1:0] thrs[6];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_INITIAL_SPEED;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    action_i        = ACT_ADVANCE;
    host_ns_i       = '0;
    pause_request_i = 1'b0;
    new_speed_i     = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_off_req    = 1'b0;
    hold_off_len    = 0;
    host_cursor     = '0;
    pause_level     = 1'b0;
    thr_now         = GapReset;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part, reset configuration: speed 1, default threshold
    send_fields(ACT_PEEK, 64'd100, 1'b0, 8'd0);        // peek before start
    send_fields(ACT_ADVANCE, 64'd1000, 1'b1, 8'd0);    // first item ignores pause
    send_fields(ACT_ADVANCE, 64'd2000, 1'b1, 8'd0);    // pause edge right away
    send_fields(ACT_ADVANCE, 64'd1500, 1'b0, 8'd0);    // resume edge behind
    send_fields(ACT_ADVANCE, 64'd2500, 1'b0, 8'd0);
    send_fields(ACT_PEEK, 64'd5000, 1'b0, 8'd0);
    send_fields(ACT_SPARE, 64'd6000, 1'b0, 8'd9);
    send_fields(ACT_PEEK, 64'd10, 1'b0, 8'd0);         // backward peek
    send_fields(ACT_ADVANCE, 64'd2500, 1'b0, 8'd0);    // equal step
    send_fields(ACT_ADVANCE, 64'd500, 1'b0, 8'd0);     // backward step
    send_fields(ACT_SET_SPEED, 64'd3000, 1'b0, 8'd0);  // zero speed runs as one
    send_fields(ACT_SET_SPEED, 64'd4000, 1'b0, 8'd255);
    send_fields(ACT_ADVANCE, 64'd5000, 1'b0, 8'd0);
    h = 64'd5000 + 64'd250000001;
    send_fields(ACT_PEEK, h, 1'b0, 8'd0);              // peek over threshold
    send_fields(ACT_ADVANCE, h, 1'b0, 8'd0);           // gap
    h += 64'd250000000;
    send_fields(ACT_ADVANCE, h, 1'b0, 8'd0);           // exactly at threshold
    send_fields(ACT_ADVANCE, h + 64'd100, 1'b1, 8'd0); // pause edge
    send_fields(ACT_ADVANCE, h + 64'd900, 1'b1, 8'd0); // held pause
    send_fields(ACT_PEEK, h + 64'd950, 1'b1, 8'd0);
    send_fields(ACT_ADVANCE, h + 64'd5900, 1'b0, 8'd0);   // resume edge, excluded
    send_fields(ACT_ADVANCE, h + 64'd5000, 1'b1, 8'd0);   // pause edge behind
    send_fields(ACT_SET_SPEED, h + 64'd6000, 1'b0, 8'h55); // resume plus speed
    send_fields(ACT_SET_SPEED, h + 64'd7000, 1'b1, 8'hAA); // pause plus speed
    send_fields(ACT_ADVANCE, h + 64'd8000, 1'b0, 8'd0);
    send_fields(ACT_ADVANCE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0); // huge gap
    send_fields(ACT_ADVANCE, 64'd0, 1'b0, 8'd0);
    drain();

    speeds[0] = 8'd0;   thrs[0] = 40'd0;
    speeds[1] = 8'd255; thrs[1] = 40'hFF_FFFF_FFFF;
    speeds[2] = 8'd3;   thrs[2] = 40'd1000;
    speeds[3] = 8'd1;   thrs[3] = GapReset;
    speeds[4] = 8'd200; thrs[4] = 40'd1;
    speeds[5] = 8'($urandom_range(255)); thrs[5] = {8'($urandom_range(255)), $urandom};

    for (int p = 0; p < 6; p++) begin
      // upper data bits are don't-care for the speed register
      write_reg(CFG_INITIAL_SPEED, {((p % 2 == 1) ? 32'($urandom) : 32'd0), speeds[p]});
      write_reg(CFG_GAP_THRESHOLD, thrs[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;  stall_pct = 0;
        end
        1: begin
          send_idle_pct = 78; stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  stall_pct = 78;
        end
        default: begin
          send_idle_pct = 33; stall_pct = 33;
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        if (n == 60 && (p % 4 == 0 || p == 3)) begin
          hold_off_len = 150;
          hold_off_req = 1'b1;
        end
        if (n == 100 && p == 1) begin
          drain();
        end
        if (n == 140) begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        random_item(it);
        send_item(it);
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (clock_model.failures == 0 && clock_model.pending() == 0) begin
      $display("** gap_skipping_scaled_guest_clock: PASSED **");
    end else begin
      $display("** gap_skipping_scaled_guest_clock: FAILED **");
    end
    $finish;
  end

endmodule
